[rtl/rmf3_pkg.sv]
// Package for the RGB 3x3 median filter: widths, defaults, register indexes, sort helpers.
package rmf3_pkg;

  localparam int SampleW        = 8;
  localparam int OutRowW        = 12;
  localparam int OutColW        = 13;
  localparam int CfgRowBytesW   = 14;
  localparam int CfgRowCountW   = 13;
  localparam int CfgDataW       = 14;
  localparam int CfgIndexW      = 1;

  localparam int MaxRowBytesDef   = 8192;
  localparam int BytesPerPixelDef = 3;
  localparam int MaxRowsDef       = 4096;

  localparam logic [CfgRowBytesW-1:0] RowBytesRst = CfgRowBytesW'(1920);
  localparam logic [CfgRowCountW-1:0] RowCountRst = CfgRowCountW'(480);

  localparam logic [CfgIndexW-1:0] RegRowBytes = 1'b0;
  localparam logic [CfgIndexW-1:0] RegRowCount = 1'b1;

  typedef logic [SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t lo;
    sample_t md;
    sample_t hi;
  } trio_t;

  function automatic trio_t sort3(sample_t a, sample_t b, sample_t c);
    sample_t x0;
    sample_t x1;
    sample_t y1;
    sample_t y2;
    trio_t   r;
    x0 = (a < b) ? a : b;
    x1 = (a < b) ? b : a;
    y1 = (x1 < c) ? x1 : c;
    y2 = (x1 < c) ? c : x1;
    r.lo = (x0 < y1) ? x0 : y1;
    r.md = (x0 < y1) ? y1 : x0;
    r.hi = y2;
    return r;
  endfunction

  function automatic sample_t max3(sample_t a, sample_t b, sample_t c);
    sample_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic sample_t min3(sample_t a, sample_t b, sample_t c);
    sample_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic sample_t med3(sample_t a, sample_t b, sample_t c);
    trio_t t;
    t = sort3(a, b, c);
    return t.md;
  endfunction

endpackage

[rtl/rgb_median_filter_3x3.sv]
// RGB 3x3 median filter: line memory, window taps and median pipeline.
// Each result passes stage registers B, C, D and E, then the output register.
// Throughput: one input word per cycle; set by the single line-memory read/write port pair.
// in_ready_o drops only when every pipeline stage holds a word and the output is stalled.
// Reset clears positions, window taps, pipeline valids and sets the size registers to
// 1920 bytes by 480 rows; the line memory is not cleared and needs no clearing pass.
module rgb_median_filter_3x3 #(
  parameter int MAX_ROW_BYTES   = rmf3_pkg::MaxRowBytesDef,
  parameter int BYTES_PER_PIXEL = rmf3_pkg::BytesPerPixelDef,
  parameter int MAX_ROWS        = rmf3_pkg::MaxRowsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [rmf3_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [rmf3_pkg::CfgDataW-1:0]  cfg_data_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rmf3_pkg::SampleW-1:0]   sample_i,
  input  logic                           frame_start_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rmf3_pkg::SampleW-1:0]   median_o,
  output logic [rmf3_pkg::OutRowW-1:0]   out_row_o,
  output logic [rmf3_pkg::OutColW-1:0]   out_column_o,
  output logic                           last_o
);

  localparam int ColW    = $clog2(MAX_ROW_BYTES);
  localparam int RowW    = $clog2(MAX_ROWS);
  localparam int RbNeed  = $clog2(MAX_ROW_BYTES + 1);
  localparam int RcNeed  = $clog2(MAX_ROWS + 1);
  localparam int RbW     = (rmf3_pkg::CfgRowBytesW > RbNeed) ? rmf3_pkg::CfgRowBytesW : RbNeed;
  localparam int RcW     = (rmf3_pkg::CfgRowCountW > RcNeed) ? rmf3_pkg::CfgRowCountW : RcNeed;
  localparam int TapCols = 2 * BYTES_PER_PIXEL + 1;
  localparam int SW      = rmf3_pkg::SampleW;

  // ---------------------------------------------------------------------------
  // Size registers, clamped at use to 1..MAX
  // ---------------------------------------------------------------------------
  logic [rmf3_pkg::CfgRowBytesW-1:0] row_bytes_q;
  logic [rmf3_pkg::CfgRowCountW-1:0] row_count_q;
  logic [RbW-1:0] rb_raw, rb;
  logic [RcW-1:0] rc_raw, rc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= rmf3_pkg::RowBytesRst;
      row_count_q <= rmf3_pkg::RowCountRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rmf3_pkg::RegRowBytes: row_bytes_q <= cfg_data_i[rmf3_pkg::CfgRowBytesW-1:0];
        rmf3_pkg::RegRowCount: row_count_q <= cfg_data_i[rmf3_pkg::CfgRowCountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rb_raw = RbW'(row_bytes_q);
    rc_raw = RcW'(row_count_q);
    if (rb_raw == '0) begin
      rb = RbW'(1);
    end else if (rb_raw > RbW'(MAX_ROW_BYTES)) begin
      rb = RbW'(MAX_ROW_BYTES);
    end else begin
      rb = rb_raw;
    end
    if (rc_raw == '0) begin
      rc = RcW'(1);
    end else if (rc_raw > RcW'(MAX_ROWS)) begin
      rc = RcW'(MAX_ROWS);
    end else begin
      rc = rc_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: each stage moves on when the next one is empty or moving
  // ---------------------------------------------------------------------------
  logic vb_q, vc_q, vd_q, ve_q, vo_q;
  logic rdy_o, rdy_e, rdy_d, rdy_c, rdy_b;
  logic accept, b_move;

  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy_e      = !ve_q || rdy_o;
  assign rdy_d      = !vd_q || rdy_e;
  assign rdy_c      = !vc_q || rdy_d;
  assign rdy_b      = !vb_q || rdy_c;
  assign in_ready_o = rdy_b;
  assign accept     = in_valid_i && rdy_b;
  assign b_move     = vb_q && rdy_c;

  // ---------------------------------------------------------------------------
  // Stage A: position of the incoming word, line memory read
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] col_q, col_d, col_a;
  logic [RowW-1:0] row_q, row_d, row_a;
  logic [RbW-1:0]  col_a_inc;
  logic [RcW-1:0]  row_a_inc;

  always_comb begin
    col_a     = frame_start_i ? '0 : col_q;
    row_a     = frame_start_i ? '0 : row_q;
    col_a_inc = RbW'(col_a) + RbW'(1);
    row_a_inc = RcW'(row_a) + RcW'(1);
    col_d     = col_q;
    row_d     = row_q;
    if (accept) begin
      if (col_a_inc >= rb) begin
        col_d = '0;
        row_d = (row_a_inc >= rc) ? '0 : row_a_inc[RowW-1:0];
      end else begin
        col_d = col_a_inc[ColW-1:0];
        row_d = row_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line memory: upper byte in the high half, middle byte in the low half
  logic [2*SW-1:0] line_mem [MAX_ROW_BYTES];
  logic [2*SW-1:0] rd_q;
  logic [2*SW-1:0] wr_data;
  logic [ColW-1:0] col_b_q;

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      line_mem[col_b_q] <= wr_data;
    end
    if (accept) begin
      rd_q <= line_mem[col_a];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: forwarding, memory write-back, window shift, border check
  // ---------------------------------------------------------------------------
  logic [RowW-1:0] row_b_q;
  logic [SW-1:0]   sample_b_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_b_q    <= col_a;
      row_b_q    <= row_a;
      sample_b_q <= sample_i;
    end
  end

  // The word just ahead may have written this same entry after our read (when a row is one
  // byte long, or a frame start follows a column-0 word); take its data instead.
  logic            lw_vld_q;
  logic [ColW-1:0] lw_col_q;
  logic [2*SW-1:0] lw_data_q;
  logic [SW-1:0]   up_b, mid_b;

  always_comb begin
    if (lw_vld_q && (lw_col_q == col_b_q)) begin
      up_b  = lw_data_q[2*SW-1:SW];
      mid_b = lw_data_q[SW-1:0];
    end else begin
      up_b  = rd_q[2*SW-1:SW];
      mid_b = rd_q[SW-1:0];
    end
    wr_data = {mid_b, sample_b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_vld_q <= 1'b0;
    end else if (b_move) begin
      lw_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      lw_col_q  <= col_b_q;
      lw_data_q <= wr_data;
    end
  end

  // Window taps: three rows, oldest byte at index 0
  logic [SW-1:0] win_q [3][TapCols];
  logic [SW-1:0] win_in [3];

  assign win_in[0] = up_b;
  assign win_in[1] = mid_b;
  assign win_in[2] = sample_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < TapCols; k++) begin
          win_q[r][k] <= '0;
        end
      end
    end else if (b_move) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < TapCols - 1; k++) begin
          win_q[r][k] <= win_q[r][k+1];
        end
        win_q[r][TapCols-1] <= win_in[r];
      end
    end
  end

  // Interior test and result position
  logic [RbW-1:0]              col_b_ext;
  logic [RcW-1:0]              row_b_ext;
  logic                        interior_b, last_b;
  logic [rmf3_pkg::OutRowW-1:0] orow_b;
  logic [rmf3_pkg::OutColW-1:0] ocol_b;
  logic [RbW-1:0]              ocol_full;
  logic [RcW-1:0]              orow_full;

  always_comb begin
    col_b_ext  = RbW'(col_b_q);
    row_b_ext  = RcW'(row_b_q);
    interior_b = (row_b_ext >= RcW'(2)) && (row_b_ext < rc) &&
                 (col_b_ext >= RbW'(2 * BYTES_PER_PIXEL)) && (col_b_ext < rb);
    last_b     = (row_b_ext == rc - RcW'(1)) && (col_b_ext == rb - RbW'(1));
    orow_full  = row_b_ext - RcW'(1);
    ocol_full  = col_b_ext - RbW'(BYTES_PER_PIXEL);
    orow_b     = orow_full[rmf3_pkg::OutRowW-1:0];
    ocol_b     = ocol_full[rmf3_pkg::OutColW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage C: the nine neighbors, taken from the window after this shift
  // ---------------------------------------------------------------------------
  logic [SW-1:0]               nine_q [3][3];
  logic [rmf3_pkg::OutRowW-1:0] orow_c_q, orow_d_q, orow_e_q;
  logic [rmf3_pkg::OutColW-1:0] ocol_c_q, ocol_d_q, ocol_e_q;
  logic                        last_c_q, last_d_q, last_e_q;

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      for (int r = 0; r < 3; r++) begin
        nine_q[r][0] <= win_q[r][1];
        nine_q[r][1] <= win_q[r][BYTES_PER_PIXEL+1];
        nine_q[r][2] <= win_in[r];
      end
      orow_c_q <= orow_b;
      ocol_c_q <= ocol_b;
      last_c_q <= last_b;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: sort each row of three
  // ---------------------------------------------------------------------------
  rmf3_pkg::trio_t srt_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy_d) begin
      for (int r = 0; r < 3; r++) begin
        srt_q[r] <= rmf3_pkg::sort3(nine_q[r][0], nine_q[r][1], nine_q[r][2]);
      end
      orow_d_q <= orow_c_q;
      ocol_d_q <= ocol_c_q;
      last_d_q <= last_c_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: max of mins, median of medians, min of maxes
  // ---------------------------------------------------------------------------
  rmf3_pkg::trio_t cand_q;

  always_ff @(posedge clk_i) begin
    if (rdy_e) begin
      cand_q.lo <= rmf3_pkg::max3(srt_q[0].lo, srt_q[1].lo, srt_q[2].lo);
      cand_q.md <= rmf3_pkg::med3(srt_q[0].md, srt_q[1].md, srt_q[2].md);
      cand_q.hi <= rmf3_pkg::min3(srt_q[0].hi, srt_q[1].hi, srt_q[2].hi);
      orow_e_q  <= orow_d_q;
      ocol_e_q  <= ocol_d_q;
      last_e_q  <= last_d_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: median of the three candidates
  // ---------------------------------------------------------------------------
  logic [SW-1:0]               median_q;
  logic [rmf3_pkg::OutRowW-1:0] orow_o_q;
  logic [rmf3_pkg::OutColW-1:0] ocol_o_q;
  logic                        last_o_q;

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      median_q <= rmf3_pkg::med3(cand_q.lo, cand_q.md, cand_q.hi);
      orow_o_q <= orow_e_q;
      ocol_o_q <= ocol_e_q;
      last_o_q <= last_e_q;
    end
  end

  // Stage valids; border words are dropped after stage B
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_b) vb_q <= in_valid_i;
      if (rdy_c) vc_q <= vb_q && interior_b;
      if (rdy_d) vd_q <= vc_q;
      if (rdy_e) ve_q <= vd_q;
      if (rdy_o) vo_q <= ve_q;
    end
  end

  assign out_valid_o  = vo_q;
  assign median_o     = median_q;
  assign out_row_o    = orow_o_q;
  assign out_column_o = ocol_o_q;
  assign last_o       = last_o_q;

endmodule
